### sv/qoi_pkg.sv
// Shared types and opcode constants for the QOI pixel encoder.
package qoi_pkg;

    localparam int IDX_DEPTH  = 64;
    localparam int IDX_AW     = 6;
    localparam int PX_W       = 32;
    localparam int MAX_BYTES  = 6;
    localparam int CNT_W      = 3;
    localparam int RUN_MAX    = 62;

    localparam logic [7:0] OP_INDEX = 8'h00;
    localparam logic [7:0] OP_DIFF  = 8'h40;
    localparam logic [7:0] OP_LUMA  = 8'h80;
    localparam logic [7:0] OP_RUN   = 8'hC0;
    localparam logic [7:0] OP_RGB   = 8'hFE;
    localparam logic [7:0] OP_RGBA  = 8'hFF;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } pixel_t;

    // Bytes one pixel causes, oldest first at data[0].
    typedef struct packed {
        logic [CNT_W-1:0]            count;
        byte_t [MAX_BYTES-1:0]       data;
        logic                        frame_end;
    } chunk_t;

endpackage

### sv/qoi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module qoi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns the old contents on a same-address write.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/qoi_chunk_enc.sv
// Chunk selection: run, index, diff, luma, rgb and rgba bytes for one pixel.
module qoi_chunk_enc import qoi_pkg::*; (
    input  pixel_t            px,
    input  pixel_t            prev,
    input  logic [5:0]        run,
    input  pixel_t            entry,
    input  logic              entry_ok,
    input  logic [IDX_AW-1:0] hash,
    input  logic              last,
    output chunk_t            chunk,
    output logic              idx_write,
    output logic              repeat_px
);

    logic [7:0]       vr;
    logic [7:0]       vg;
    logic [7:0]       vb;
    logic [8:0]       vgr;
    logic [8:0]       vgb;
    logic             hit;
    logic             diff_ok;
    logic             luma_ok;
    byte_t            body [5];
    logic [CNT_W-1:0] body_len;

    assign vr  = px.r - prev.r;
    assign vg  = px.g - prev.g;
    assign vb  = px.b - prev.b;
    assign vgr = {vr[7], vr} - {vg[7], vg};
    assign vgb = {vb[7], vb} - {vg[7], vg};

    assign repeat_px = (px == prev);
    // An entry not yet written this frame reads as all zero.
    assign hit       = entry_ok ? (entry == px) : (px == '0);
    assign idx_write = !repeat_px && !hit;

    assign diff_ok = ($signed(vr) > -8'sd3) && ($signed(vr) < 8'sd2)
                  && ($signed(vg) > -8'sd3) && ($signed(vg) < 8'sd2)
                  && ($signed(vb) > -8'sd3) && ($signed(vb) < 8'sd2);

    assign luma_ok = ($signed(vgr) > -9'sd9) && ($signed(vgr) < 9'sd8)
                  && ($signed(vg) > -8'sd33) && ($signed(vg) < 8'sd32)
                  && ($signed(vgb) > -9'sd9) && ($signed(vgb) < 9'sd8);

    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            body[i] = '0;
        end
        body_len = '0;
        if (hit)
        begin
            body[0]  = OP_INDEX | {2'b00, hash};
            body_len = CNT_W'(1);
        end
        else if (px.a == prev.a)
        begin
            if (diff_ok)
            begin
                // Bias of 2 on a 2-bit field flips the upper bit.
                body[0]  = OP_DIFF | {2'b00, ~vr[1], vr[0], ~vg[1], vg[0], ~vb[1], vb[0]};
                body_len = CNT_W'(1);
            end
            else if (luma_ok)
            begin
                body[0]  = OP_LUMA | {2'b00, ~vg[5], vg[4:0]};
                body[1]  = {~vgr[3], vgr[2:0], ~vgb[3], vgb[2:0]};
                body_len = CNT_W'(2);
            end
            else
            begin
                body[0]  = OP_RGB;
                body[1]  = px.r;
                body[2]  = px.g;
                body[3]  = px.b;
                body_len = CNT_W'(4);
            end
        end
        else
        begin
            body[0]  = OP_RGBA;
            body[1]  = px.r;
            body[2]  = px.g;
            body[3]  = px.b;
            body[4]  = px.a;
            body_len = CNT_W'(5);
        end
    end

    always_comb
    begin
        chunk.data      = '0;
        chunk.count     = '0;
        chunk.frame_end = last;
        if (repeat_px)
        begin
            // Run byte carries length-1, and the new length is run+1.
            chunk.data[0] = OP_RUN | {2'b00, run};
            if ((run == 6'(RUN_MAX - 1)) || last)
            begin
                chunk.count = CNT_W'(1);
            end
        end
        else if (run != '0)
        begin
            chunk.data[0] = OP_RUN | {2'b00, 6'(run - 6'd1)};
            for (int i = 0; i < 5; i++)
            begin
                chunk.data[i+1] = body[i];
            end
            chunk.count = body_len + CNT_W'(1);
        end
        else
        begin
            for (int i = 0; i < 5; i++)
            begin
                chunk.data[i] = body[i];
            end
            chunk.count = body_len;
        end
    end

endmodule

### sv/qoi_byte_emit.sv
// Output buffer: holds one pixel's bytes and sends them one byte at a time.
module qoi_byte_emit import qoi_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  chunk_t     chunk,
    output logic       free,
    output logic       byte_valid,
    input  logic       byte_stall,
    output logic [7:0] code_byte,
    output logic       last_of_item,
    output logic       frame_done
);

    logic                            busy_reg;
    logic [$clog2(MAX_BYTES)-1:0]    pos_reg;
    logic [CNT_W-1:0]                len_reg;
    byte_t [MAX_BYTES-1:0]           data_reg;
    logic                            fend_reg;
    logic                            at_end;
    logic                            finish;

    assign at_end = (CNT_W'(pos_reg) == len_reg - CNT_W'(1));
    assign finish = busy_reg && !byte_stall && at_end;
    assign free   = !busy_reg || finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            pos_reg  <= '0;
        end
        else if (busy_reg && !byte_stall)
        begin
            if (at_end)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            len_reg  <= chunk.count;
            data_reg <= chunk.data;
            fend_reg <= chunk.frame_end;
        end
    end

    assign byte_valid   = busy_reg;
    assign code_byte    = data_reg[pos_reg];
    assign last_of_item = at_end;
    assign frame_done   = at_end && fend_reg;

endmodule

### sv/qoi_pixel_encoder.sv
// Top level of the QOI pixel encoder: hash stage, index lookup, state update.
//
// Pixels enter on the pixel channel (red, green, blue, alpha, frame_end with
// pixel_valid / pixel_stall); QOI chunk bytes leave on the byte channel
// (code_byte, last_of_item, frame_done with byte_valid / byte_stall).
// No file header or end marker is produced.
// An accepted pixel has its hash computed and the colour index read in the
// same cycle; the pixel and hash are registered, then the chunk is chosen,
// state is updated and the bytes move to the output buffer when it is free
// or no byte is due. The first byte is valid in the cycle after the load.
// Throughput is one pixel per cycle while each pixel causes at most one byte
// and byte_stall is low; a pixel causing more bytes holds the pixel channel,
// since the output buffer sends one byte per cycle when not stalled. A repeat
// that only extends a run causes no byte and does not wait for the buffer.
// The colour index is a 64-entry RAM with per-entry valid flops; a frame-end
// pixel clears all valid flops at once, so there is no clearing pass.
// Reset empties the pipeline and output buffer and sets the previous pixel
// to opaque black with no pending run. While byte_stall is high the current
// byte holds and the pixel channel stalls once the output buffer is taken.
module qoi_pixel_encoder import qoi_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic [7:0] alpha,
    input  logic       frame_end,
    input  logic       pixel_valid,
    output logic       pixel_stall,
    output logic [7:0] code_byte,
    output logic       last_of_item,
    output logic       frame_done,
    output logic       byte_valid,
    input  logic       byte_stall
);

    logic                  pixel_accept;
    logic [IDX_AW-1:0]     hash;

    logic                  s1_valid_reg;
    pixel_t                s1_px_reg;
    logic [IDX_AW-1:0]     s1_hash_reg;
    logic                  s1_last_reg;
    logic                  s1_go;

    pixel_t                prev_reg;
    logic [5:0]            run_reg;
    logic [IDX_DEPTH-1:0]  idx_valid_reg;

    logic                  fwd_valid_reg;
    logic [IDX_AW-1:0]     fwd_addr_reg;
    pixel_t                fwd_data_reg;

    logic [PX_W-1:0]       ram_rdata;
    pixel_t                entry;
    chunk_t                chunk;
    logic                  idx_write;
    logic                  repeat_px;
    logic                  ram_we;
    logic                  emit_load;
    logic                  emit_free;

    assign pixel_accept = pixel_valid && !pixel_stall;
    assign hash = 6'(red[5:0] * 6'd3 + green[5:0] * 6'd5 + blue[5:0] * 6'd7
                     + alpha[5:0] * 6'd11);

    assign s1_go       = s1_valid_reg && ((chunk.count == '0) || emit_free);
    assign pixel_stall = s1_valid_reg && !s1_go;
    assign ram_we      = s1_go && idx_write;
    assign emit_load   = s1_go && (chunk.count != '0);

    qoi_ram #(
        .WIDTH (PX_W),
        .DEPTH (IDX_DEPTH)
    ) u_index (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_hash_reg),
        .wdata (s1_px_reg),
        .re    (pixel_accept),
        .raddr (hash),
        .rdata (ram_rdata)
    );

    // Forward the write made in the cycle the read was issued.
    assign entry = (fwd_valid_reg && (fwd_addr_reg == s1_hash_reg))
                 ? fwd_data_reg : pixel_t'(ram_rdata);

    qoi_chunk_enc u_enc (
        .px        (s1_px_reg),
        .prev      (prev_reg),
        .run       (run_reg),
        .entry     (entry),
        .entry_ok  (idx_valid_reg[s1_hash_reg]),
        .hash      (s1_hash_reg),
        .last      (s1_last_reg),
        .chunk     (chunk),
        .idx_write (idx_write),
        .repeat_px (repeat_px)
    );

    qoi_byte_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (emit_load),
        .chunk        (chunk),
        .free         (emit_free),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .code_byte    (code_byte),
        .last_of_item (last_of_item),
        .frame_done   (frame_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            prev_reg      <= '{r: 8'h00, g: 8'h00, b: 8'h00, a: ALPHA_OPAQUE};
            run_reg       <= '0;
            idx_valid_reg <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            if (pixel_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_go)
            begin
                if (s1_last_reg)
                begin
                    // Frame end: drop the index and restart from opaque black.
                    prev_reg      <= '{r: 8'h00, g: 8'h00, b: 8'h00, a: ALPHA_OPAQUE};
                    run_reg       <= '0;
                    idx_valid_reg <= '0;
                    fwd_valid_reg <= 1'b0;
                end
                else
                begin
                    if (repeat_px)
                    begin
                        run_reg <= (run_reg == 6'(RUN_MAX - 1)) ? '0 : run_reg + 6'd1;
                    end
                    else
                    begin
                        prev_reg <= s1_px_reg;
                        run_reg  <= '0;
                    end
                    if (idx_write)
                    begin
                        idx_valid_reg[s1_hash_reg] <= 1'b1;
                        fwd_valid_reg              <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_accept)
        begin
            s1_px_reg   <= '{r: red, g: green, b: blue, a: alpha};
            s1_hash_reg <= hash;
            s1_last_reg <= frame_end;
        end
        if (ram_we)
        begin
            fwd_addr_reg <= s1_hash_reg;
            fwd_data_reg <= s1_px_reg;
        end
    end

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit_load |-> emit_free)
        else $error("output buffer loaded while still sending");

    a_frame_end_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_last_reg) |-> (chunk.count != '0))
        else $error("frame-end pixel produced no byte");

    a_index_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && s1_last_reg) |=> (idx_valid_reg == '0) && !fwd_valid_reg)
        else $error("colour index not cleared after frame end");

    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && repeat_px && !s1_last_reg && (run_reg == 6'(RUN_MAX - 1)))
        |=> (run_reg == '0))
        else $error("run not closed at its limit");
`endif

endmodule

### test/qoi_pixel_encoder_tb.sv
// Testbench for qoi_pixel_encoder: random and directed pixel streams with a predictor.
`timescale 1ns / 1ps

module qoi_pixel_encoder_tb;
    import qoi_pkg::*;

    localparam int     SCAN_LIMIT   = 200000;
    localparam int     TARGET_ITEMS = 440;
    localparam int     HOLD_START   = 150;
    localparam int     HOLD_LEN     = 400;
    localparam pixel_t OPAQUE_BLACK = '{r: 8'h00, g: 8'h00, b: 8'h00, a: ALPHA_OPAQUE};

    typedef struct {
        pixel_t px;
        logic   fe;
    } pixel_word_t;

    typedef struct {
        byte_t code_byte;
        logic  last_of_item;
        logic  frame_done;
    } code_word_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic [7:0] red          = 8'h00;
    logic [7:0] green        = 8'h00;
    logic [7:0] blue         = 8'h00;
    logic [7:0] alpha        = 8'h00;
    logic       frame_end    = 1'b0;
    logic       pixel_valid  = 1'b0;
    logic       pixel_stall;
    logic [7:0] code_byte;
    logic       last_of_item;
    logic       frame_done;
    logic       byte_valid;
    logic       byte_stall   = 1'b0;

    // encoder state as the model sees it
    pixel_t      last_px;
    int          run_len;
    pixel_t      colour_tab [IDX_DEPTH];

    pixel_word_t pending_px [$];
    code_word_t  expected_words [$];
    pixel_t      seen_px [$];
    pixel_t      gen_prev;

    pixel_word_t next_word;
    code_word_t  want;
    int          send_gap     = 0;
    int          stall_gap    = 0;
    int          pixels_in    = 0;
    int          hold_cycles  = 0;
    int          cycle_count  = 0;
    int          mismatches   = 0;
    logic        tail_phase   = 1'b0;
    logic        long_hold    = 1'b0;
    logic        hold_done    = 1'b0;

    qoi_pixel_encoder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .frame_end    (frame_end),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .code_byte    (code_byte),
        .last_of_item (last_of_item),
        .frame_done   (frame_done),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall)
    );

    always #2 clk = ~clk;

    function automatic void clear_state();
        last_px = OPAQUE_BLACK;
        run_len = 0;
        foreach (colour_tab[i])
            colour_tab[i] = '0;
    endfunction

    // Work out the chunk bytes one pixel causes and queue them.
    function automatic void encode_pixel(pixel_t px, logic fe);
        byte_t             bytes [$];
        code_word_t        w;
        logic [IDX_AW-1:0] slot;
        logic signed [7:0] dr, dg, db;
        int                vr, vg, vb, vgr, vgb;
        if (px == last_px)
        begin
            run_len++;
            if (run_len == RUN_MAX)
            begin
                bytes = {bytes, OP_RUN | byte_t'(run_len - 1)};
                run_len = 0;
            end
        end
        else
        begin
            if (run_len != 0)
            begin
                bytes = {bytes, OP_RUN | byte_t'(run_len - 1)};
                run_len = 0;
            end
            slot = IDX_AW'(3 * px.r + 5 * px.g + 7 * px.b + 11 * px.a);
            if (colour_tab[slot] == px)
                bytes = {bytes, OP_INDEX | byte_t'(slot)};
            else
            begin
                colour_tab[slot] = px;
                if (px.a == last_px.a)
                begin
                    // channel differences wrap modulo 256
                    dr = px.r - last_px.r;
                    dg = px.g - last_px.g;
                    db = px.b - last_px.b;
                    vr = dr;
                    vg = dg;
                    vb = db;
                    vgr = vr - vg;
                    vgb = vb - vg;
                    if (vr >= -2 && vr <= 1 && vg >= -2 && vg <= 1 && vb >= -2 && vb <= 1)
                        bytes = {bytes, OP_DIFF | byte_t'(((vr + 2) << 4)
                                                          | ((vg + 2) << 2)
                                                          | (vb + 2))};
                    else if (vgr >= -8 && vgr <= 7 && vg >= -32 && vg <= 31
                             && vgb >= -8 && vgb <= 7)
                    begin
                        bytes = {bytes, OP_LUMA | byte_t'(vg + 32)};
                        bytes = {bytes, byte_t'(((vgr + 8) << 4) | (vgb + 8))};
                    end
                    else
                        bytes = {bytes, OP_RGB, px.r, px.g, px.b};
                end
                else
                    bytes = {bytes, OP_RGBA, px.r, px.g, px.b, px.a};
            end
            last_px = px;
        end
        if (fe)
        begin
            if (run_len != 0)
                bytes = {bytes, OP_RUN | byte_t'(run_len - 1)};
            clear_state();
        end
        foreach (bytes[i])
        begin
            w.code_byte    = bytes[i];
            w.last_of_item = (i == bytes.size() - 1);
            w.frame_done   = fe && w.last_of_item;
            expected_words = {expected_words, w};
        end
    endfunction

    function automatic void add_pixel(pixel_t p, logic fe);
        pixel_word_t w;
        w.px = p;
        w.fe = fe;
        pending_px = {pending_px, w};
        seen_px = {seen_px, p};
        if (seen_px.size() > IDX_DEPTH)
            void'(seen_px.pop_front());
        gen_prev = fe ? OPAQUE_BLACK : p;
    endfunction

    function automatic void add_delta(int dr, int dg, int db, logic fe);
        pixel_t p;
        p = gen_prev;
        p.r = p.r + 8'(dr);
        p.g = p.g + 8'(dg);
        p.b = p.b + 8'(db);
        add_pixel(p, fe);
    endfunction

    // Sender: offer pixels from the pending queue, with random gaps.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_valid && !pixel_stall)
            begin
                encode_pixel({red, green, blue, alpha}, frame_end);
                pixels_in <= pixels_in + 1;
            end
            if (!pixel_valid || !pixel_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap    <= send_gap - 1;
                    pixel_valid <= 1'b0;
                end
                else if (pending_px.size() > 0)
                begin
                    next_word   = pending_px.pop_front();
                    red         <= next_word.px.r;
                    green       <= next_word.px.g;
                    blue        <= next_word.px.b;
                    alpha       <= next_word.px.a;
                    frame_end   <= next_word.fe;
                    pixel_valid <= 1'b1;
                    if (!tail_phase && $urandom_range(0, 7) == 0)
                        send_gap <= $urandom_range(1, 14);
                end
                else
                    pixel_valid <= 1'b0;
            end
            tail_phase <= (pending_px.size() < 60);
        end
    end

    // Receiver: check each accepted word and stall in random bursts.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("code_byte: expected nothing, got %02h", code_byte);
                    mismatches++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (code_byte !== want.code_byte)
                    begin
                        $error("code_byte: expected %02h, got %02h", want.code_byte, code_byte);
                        mismatches++;
                    end
                    if (last_of_item !== want.last_of_item)
                    begin
                        $error("last_of_item: expected %0b, got %0b",
                               want.last_of_item, last_of_item);
                        mismatches++;
                    end
                    if (frame_done !== want.frame_done)
                    begin
                        $error("frame_done: expected %0b, got %0b", want.frame_done, frame_done);
                        mismatches++;
                    end
                end
            end
            if (stall_gap > 0)
            begin
                stall_gap  <= stall_gap - 1;
                byte_stall <= 1'b1;
            end
            else if (long_hold)
                byte_stall <= 1'b1;
            else if (!tail_phase && $urandom_range(0, 9) == 0)
            begin
                stall_gap  <= $urandom_range(0, 13);
                byte_stall <= 1'b1;
            end
            else
                byte_stall <= 1'b0;
        end
    end

    // Hold off the receiver once so the encoder backs up into the pixel side.
    always @(posedge clk)
    begin
        if (!hold_done && pixels_in >= HOLD_START)
        begin
            if (hold_cycles == HOLD_LEN)
            begin
                long_hold <= 1'b0;
                hold_done <= 1'b1;
            end
            else
            begin
                long_hold   <= 1'b1;
                hold_cycles <= hold_cycles + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == SCAN_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int     kind;
        int     n;
        int     vg;
        logic   fe;
        pixel_t p;

        clear_state();
        gen_prev = OPAQUE_BLACK;

        // directed: repeat of the reset pixel, all-zero pixel hitting the cleared index
        add_pixel(OPAQUE_BLACK, 1'b0);
        add_pixel('0, 1'b0);
        add_pixel('1, 1'b0);
        // smallest and largest small differences, luma extremes, then larger jumps
        add_delta(-2, -2, -2, 1'b0);
        add_delta(1, 1, 1, 1'b0);
        add_delta(-40, -32, -40, 1'b0);
        add_delta(38, 31, 38, 1'b0);
        add_delta(100, -50, 3, 1'b0);
        add_delta(-128, -128, -128, 1'b0);
        // back to white: index hit, then a short run
        add_pixel('1, 1'b0);
        add_pixel('1, 1'b0);
        add_pixel('1, 1'b0);
        // run flush plus full rgba chunk on a frame end
        add_pixel('{r: 8'h12, g: 8'h34, b: 8'h56, a: 8'h78}, 1'b1);
        // frame end on a repeat of the fresh previous pixel
        add_pixel(OPAQUE_BLACK, 1'b1);
        add_pixel('0, 1'b0);
        add_pixel('0, 1'b1);
        add_pixel('{r: 8'h80, g: 8'h80, b: 8'h80, a: ALPHA_OPAQUE}, 1'b1);
        // differences that wrap around zero
        add_pixel('{r: 8'hFF, g: 8'h00, b: 8'h01, a: ALPHA_OPAQUE}, 1'b0);
        add_delta(1, -1, 127, 1'b0);
        add_pixel('{r: 8'hFF, g: 8'h00, b: 8'h01, a: 8'h00}, 1'b0);

        while (pending_px.size() < TARGET_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            fe   = ($urandom_range(0, 39) == 0);
            if (kind < 20)
            begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(55, 70) : $urandom_range(1, 4);
                for (int k = 0; k < n; k++)
                    add_pixel(gen_prev, fe && k == n - 1);
            end
            else if (kind < 40)
                add_delta(int'($urandom_range(0, 3)) - 2, int'($urandom_range(0, 3)) - 2,
                          int'($urandom_range(0, 3)) - 2, fe);
            else if (kind < 58)
            begin
                vg = int'($urandom_range(0, 63)) - 32;
                add_delta(vg + int'($urandom_range(0, 15)) - 8, vg,
                          vg + int'($urandom_range(0, 15)) - 8, fe);
            end
            else if (kind < 70 && seen_px.size() > 0)
                add_pixel(seen_px[$urandom_range(0, seen_px.size() - 1)], fe);
            else if (kind < 82)
            begin
                p   = $urandom;
                p.a = gen_prev.a;
                add_pixel(p, fe);
            end
            else if (kind < 92)
            begin
                p = $urandom;
                add_pixel(p, fe);
            end
            else
            begin
                p   = $urandom;
                p.a = $urandom_range(0, 1) ? 8'h00 : ALPHA_OPAQUE;
                add_pixel(p, fe);
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_px.size() > 0 || pixel_valid || expected_words.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
